// File: hdl/lcd_pkg.sv
// Shared types and constants for the LRU object cache directory.
// Request and response words, operation and status codes, sequencer states.
// No dependencies.
package lcd_pkg;

   localparam int KEY_W  = 64;
   localparam int SIZE_W = 20;
   localparam int WAY_W  = 4;

   localparam logic [SIZE_W-1:0] SIZE_LIMIT_RESET = 20'd102400;

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_INSERT = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_MISS     = 2'd0,
      STATUS_HIT      = 2'd1,
      STATUS_INSERTED = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef struct packed {
      func_type          func;
      logic [KEY_W-1:0]  obj_key;
      logic [SIZE_W-1:0] obj_bytes;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [WAY_W-1:0]  way;
      logic [SIZE_W-1:0] hit_size;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Write controls from the sequencer to the entry store.
   typedef struct packed {
      logic entry_we;   // write key, size and stamp, mark valid
      logic stamp_we;   // write stamp only
   } wr_ctl_type;

endpackage

// File: hdl/lcd_store.sv
// Entry store of the cache directory: key, size and stamp memories plus valid bits.
// One registered read port and one write port. Depends on lcd_pkg.
module lcd_store #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int STAMP_BITS = 32,
   parameter int IDX_W      = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [IDX_W-1:0]           rd_addr,
   input  logic [IDX_W-1:0]           wr_addr,
   input  lcd_pkg::wr_ctl_type        wr_ctl,
   input  logic [KEY_BITS-1:0]        wr_key,
   input  logic [lcd_pkg::SIZE_W-1:0] wr_size,
   input  logic [STAMP_BITS-1:0]      wr_stamp,
   output logic                       rd_valid,
   output logic [KEY_BITS-1:0]        rd_key,
   output logic [lcd_pkg::SIZE_W-1:0] rd_size,
   output logic [STAMP_BITS-1:0]      rd_stamp
);
   import lcd_pkg::*;

   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [SIZE_W-1:0]     size_mem  [ENTRIES];
   logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

   logic [ENTRIES-1:0]    valid_ff;
   logic [ENTRIES-1:0]    valid_in;
   logic                  rd_valid_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [SIZE_W-1:0]     rd_size_ff;
   logic [STAMP_BITS-1:0] rd_stamp_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_ctl.entry_we) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.entry_we) begin
         key_mem[wr_addr]  <= wr_key;
         size_mem[wr_addr] <= wr_size;
      end
      if (wr_ctl.entry_we || wr_ctl.stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_size_ff  <= size_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_key   = rd_key_ff;
   assign rd_size  = rd_size_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

// File: hdl/lcd_seq.sv
// Sequencer of the cache directory: walks the entries one per cycle through a
// single key comparator and stamp comparator, keeps the time counter. Depends on lcd_pkg.
module lcd_seq #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int STAMP_BITS = 32,
   parameter int IDX_W      = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lcd_pkg::req_type           req_word,
   input  logic [lcd_pkg::SIZE_W-1:0] size_limit,
   output logic                       rsp_strobe,
   output lcd_pkg::rsp_type           rsp_word,
   output logic [IDX_W-1:0]           rd_addr,
   output logic [IDX_W-1:0]           wr_addr,
   output lcd_pkg::wr_ctl_type        wr_ctl,
   output logic [KEY_BITS-1:0]        wr_key,
   output logic [lcd_pkg::SIZE_W-1:0] wr_size,
   output logic [STAMP_BITS-1:0]      wr_stamp,
   input  logic                       rd_valid,
   input  logic [KEY_BITS-1:0]        rd_key,
   input  logic [lcd_pkg::SIZE_W-1:0] rd_size,
   input  logic [STAMP_BITS-1:0]      rd_stamp
);
   import lcd_pkg::*;

   localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
   localparam logic [STAMP_BITS-1:0] STAMP_TOP = '1;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   func_type              func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [STAMP_BITS-1:0] best_stamp_ff;
   logic [STAMP_BITS-1:0] time_ff, time_in;
   rsp_type               rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic                  reject;
   logic                  last;
   logic                  key_hit;
   logic                  stamp_less;
   logic [IDX_W-1:0]      cand_idx;
   logic [STAMP_BITS-1:0] cand_stamp;
   logic [STAMP_BITS-1:0] new_time;
   logic                  finish;
   status_type            fin_status;
   logic [IDX_W-1:0]      fin_idx;
   logic [SIZE_W-1:0]     fin_size;

   assign accept = start && (state_ff == ST_IDLE);
   assign reject = (req_word.func == FUNC_INSERT) && (req_word.obj_bytes > size_limit);
   assign last   = (chk_idx_ff == LAST_IDX);

   // Shared compare unit: one key compare and one stamp compare per entry.
   assign key_hit    = rd_valid && (rd_key == key_ff);
   assign stamp_less = (chk_idx_ff == '0) || (rd_stamp < best_stamp_ff);
   assign cand_idx   = stamp_less ? chk_idx_ff : best_idx_ff;
   assign cand_stamp = stamp_less ? rd_stamp : best_stamp_ff;

   // Time counter saturates at its top value.
   assign new_time = (time_ff == STAMP_TOP) ? time_ff : time_ff + 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = reject ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      rd_addr    = '0;
      wr_ctl     = '0;
      finish     = 1'b0;
      fin_status = STATUS_MISS;
      fin_idx    = chk_idx_ff;
      fin_size   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
         end
         ST_SCAN: begin
            // Prefetch the next entry; hold on the last one.
            rd_addr = last ? chk_idx_ff : IDX_W'(chk_idx_ff + 1'b1);
            if (func_ff == FUNC_LOOKUP) begin
               if (key_hit) begin
                  finish          = 1'b1;
                  fin_status      = STATUS_HIT;
                  fin_size        = rd_size;
                  wr_ctl.stamp_we = 1'b1;
               end else if (last) begin
                  finish     = 1'b1;
                  fin_status = STATUS_MISS;
               end
            end else begin
               if (!rd_valid) begin
                  finish          = 1'b1;
                  fin_status      = STATUS_INSERTED;
                  wr_ctl.entry_we = 1'b1;
               end else if (last) begin
                  finish          = 1'b1;
                  fin_status      = STATUS_INSERTED;
                  fin_idx         = cand_idx;
                  wr_ctl.entry_we = 1'b1;
               end
            end
         end
         ST_DONE: begin
            rd_addr = '0;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   assign wr_addr  = fin_idx;
   assign wr_key   = key_ff;
   assign wr_size  = size_ff;
   assign wr_stamp = new_time;

   always_comb begin
      time_in     = time_ff;
      rsp_word_in = rsp_word_ff;
      if (accept && reject) begin
         rsp_word_in.status   = STATUS_REJECTED;
         rsp_word_in.way      = '0;
         rsp_word_in.hit_size = '0;
      end else if (finish) begin
         rsp_word_in.status   = fin_status;
         rsp_word_in.way      = (fin_status == STATUS_MISS) ? '0 : WAY_W'(fin_idx);
         rsp_word_in.hit_size = fin_size;
         if (fin_status != STATUS_MISS) begin
            time_in = new_time;
         end
      end
   end

   always_comb begin
      chk_idx_in = chk_idx_ff;
      if (state_ff == ST_SCAN) begin
         if (!last) begin
            chk_idx_in = IDX_W'(chk_idx_ff + 1'b1);
         end
      end else begin
         chk_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chk_idx_ff <= '0;
         time_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         chk_idx_ff <= chk_idx_in;
         time_ff    <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_word.func;
         key_ff  <= KEY_BITS'(req_word.obj_key);
         size_ff <= req_word.obj_bytes;
      end
      if (state_ff == ST_SCAN) begin
         best_idx_ff   <= cand_idx;
         best_stamp_ff <= cand_stamp;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign rsp_word   = rsp_word_ff;

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe outside a busy period");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start the sequencer");

   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("sequencer stayed busy after the response");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (time_ff >= $past(time_ff)))
      else $error("time counter went backward");

   a_reject_is_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status == STATUS_REJECTED)) |-> (func_ff == FUNC_INSERT))
      else $error("reject reported for a lookup");

endmodule

// File: hdl/lru_object_cache_directory.sv
// A lookup or insert walks the entries from way 0, one entry read per cycle
// from the store, and strobes its response from ST_DONE when the walk ends; a
// rejected insert strobes its response in the cycle after start is accepted.
// The block takes no new word until it is idle again after the response.
// Synchronous reset clears all entries to invalid, the time counter to zero and
// size_limit to 102400. The receiver cannot stall; each response shows one cycle.
module lru_object_cache_directory #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int STAMP_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lcd_pkg::req_type           req_word,
   output logic                       rsp_strobe,
   output lcd_pkg::rsp_type           rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lcd_pkg::SIZE_W-1:0] csr_data
);
   import lcd_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [SIZE_W-1:0]     size_limit_ff;
   logic [SIZE_W-1:0]     size_limit_in;

   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   wr_ctl_type            wr_ctl;
   logic [KEY_BITS-1:0]   wr_key;
   logic [SIZE_W-1:0]     wr_size;
   logic [STAMP_BITS-1:0] wr_stamp;
   logic                  rd_valid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [SIZE_W-1:0]     rd_size;
   logic [STAMP_BITS-1:0] rd_stamp;

   assign csr_ready     = !busy;
   assign size_limit_in = (csr_valid && csr_ready) ? csr_data : size_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff <= SIZE_LIMIT_RESET;
      end else begin
         size_limit_ff <= size_limit_in;
      end
   end

   lcd_seq #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS),
      .IDX_W      (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .size_limit (size_limit_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_ctl     (wr_ctl),
      .wr_key     (wr_key),
      .wr_size    (wr_size),
      .wr_stamp   (wr_stamp),
      .rd_valid   (rd_valid),
      .rd_key     (rd_key),
      .rd_size    (rd_size),
      .rd_stamp   (rd_stamp)
   );

   lcd_store #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_ctl   (wr_ctl),
      .wr_key   (wr_key),
      .wr_size  (wr_size),
      .wr_stamp (wr_stamp),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_size  (rd_size),
      .rd_stamp (rd_stamp)
   );

endmodule

// File: tb/lru_object_cache_directory_tb.sv
// Self-checking testbench for lru_object_cache_directory: directed table, then random
// lookups and inserts under several size limits, checked against an LRU directory predictor.
// Depends on lcd_pkg and the lru_object_cache_directory RTL.
module lru_object_cache_directory_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcd_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 64;
   // Narrow stamps so the time counter saturates within the run.
   localparam int STAMP_BITS = 9;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = ENTRIES + 4;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int KEY_POOL        = 20;
   localparam int N_DIRECTED      = 26;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_word;
   logic              rsp_strobe;
   rsp_type           rsp_word;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data;

   // Predictor state
   logic                  dir_valid [ENTRIES];
   logic [KEY_W-1:0]      dir_key   [ENTRIES];
   logic [SIZE_W-1:0]     dir_size  [ENTRIES];
   logic [STAMP_BITS-1:0] dir_stamp [ENTRIES];
   logic [STAMP_BITS-1:0] dir_time;
   logic [SIZE_W-1:0]     limit_shadow;

   rsp_type          pending_rsp [$];
   logic [KEY_W-1:0] key_pool [KEY_POOL];

   int mismatch_count;
   int request_count;
   int hit_count;
   int miss_count;
   int insert_count;
   int evict_count;
   int reject_count;
   int limit_count;
   int steady_left;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{'{FUNC_LOOKUP, 64'h0, 20'd0}, 1'b1, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h0, 20'd0}, 1'b1, '{STATUS_INSERTED, 4'd0, 20'd0}},
      '{'{FUNC_LOOKUP, 64'h0, 20'd0}, 1'b1, '{STATUS_HIT, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, SIZE_LIMIT_RESET}, 1'b1,
        '{STATUS_INSERTED, 4'd1, 20'd0}},
      '{'{FUNC_INSERT, 64'h5, SIZE_LIMIT_RESET + 20'd1}, 1'b1,
        '{STATUS_REJECTED, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h6, 20'hFFFFF}, 1'b1, '{STATUS_REJECTED, 4'd0, 20'd0}},
      '{'{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF}, 1'b1,
        '{STATUS_HIT, 4'd1, SIZE_LIMIT_RESET}},
      '{'{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 20'd7}, 1'b1,
        '{STATUS_INSERTED, 4'd2, 20'd0}},
      '{'{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 20'd0}, 1'b1,
        '{STATUS_HIT, 4'd1, SIZE_LIMIT_RESET}},
      '{'{FUNC_LOOKUP, 64'h5, 20'd0}, 1'b1, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h8000_0000_0000_0000, 20'd1}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 20'd102399}, 1'b0,
        '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h0000_0001_0000_0000, 20'd4096}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h1, 20'd2}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h2, 20'd3}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h3, 20'd65536}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h4, 20'd1500}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 20'd77}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'hFEDC_BA98_7654_3210, 20'd88}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h0000_0000_FFFF_FFFF, 20'd99}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'hFFFF_FFFF_0000_0000, 20'd100}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'h00FF_00FF_00FF_00FF, 20'd101}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'hFF00_FF00_FF00_FF00, 20'd102}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_LOOKUP, 64'h0, 20'd0}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 20'd1}, 1'b0, '{STATUS_MISS, 4'd0, 20'd0}},
      '{'{FUNC_LOOKUP, 64'h5555_5555_5555_5555, 20'd0}, 1'b1, '{STATUS_MISS, 4'd0, 20'd0}}
   };

   lru_object_cache_directory #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .STAMP_BITS(STAMP_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout, %0d words still pending", $realtime, pending_rsp.size());
      $display("lru_object_cache_directory: mismatch");
      $finish;
   end

   // Apply one request to the directory copy and return the word it answers with.
   function automatic rsp_type directory_access(input req_type r);
      rsp_type res;
      int      slot;
      int      i;
      res = '{STATUS_MISS, '0, '0};
      slot = -1;
      request_count++;
      if (r.func == FUNC_LOOKUP) begin
         for (i = ENTRIES - 1; i >= 0; i--) begin
            if (dir_valid[i] && dir_key[i] == r.obj_key)
               slot = i;
         end
         if (slot < 0) begin
            miss_count++;
         end else begin
            if (dir_time != '1)
               dir_time++;
            dir_stamp[slot] = dir_time;
            res.status   = STATUS_HIT;
            res.way      = slot[WAY_W-1:0];
            res.hit_size = dir_size[slot];
            hit_count++;
         end
      end else if (r.obj_bytes > limit_shadow) begin
         res.status = STATUS_REJECTED;
         reject_count++;
      end else begin
         for (i = ENTRIES - 1; i >= 0; i--) begin
            if (!dir_valid[i])
               slot = i;
         end
         if (slot < 0) begin
            // Strictly smaller stamp wins, so ties stay with the lower way.
            slot = 0;
            for (i = 1; i < ENTRIES; i++) begin
               if (dir_stamp[i] < dir_stamp[slot])
                  slot = i;
            end
            evict_count++;
         end
         if (dir_time != '1)
            dir_time++;
         dir_valid[slot] = 1'b1;
         dir_key[slot]   = r.obj_key;
         dir_size[slot]  = r.obj_bytes;
         dir_stamp[slot] = dir_time;
         res.status = STATUS_INSERTED;
         res.way    = slot[WAY_W-1:0];
         insert_count++;
      end
      return res;
   endfunction

   function automatic int idle_gap();
      int roll;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      roll = $urandom_range(99, 0);
      if (roll < 4)
         steady_left = $urandom_range(60, 30);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      roll;
      r.func = $urandom_range(1, 0) ? FUNC_INSERT : FUNC_LOOKUP;
      if ($urandom_range(99, 0) < 88)
         r.obj_key = key_pool[$urandom_range(KEY_POOL - 1, 0)];
      else
         r.obj_key = {$urandom(), $urandom()};
      roll = $urandom_range(9, 0);
      case (roll)
         0, 1, 2, 3: r.obj_bytes = SIZE_W'($urandom());
         4, 5, 6:    r.obj_bytes = SIZE_W'($urandom_range(4096, 0));
         7:          r.obj_bytes = limit_shadow;
         8:          r.obj_bytes = limit_shadow + 1'b1;
         default:    r.obj_bytes = limit_shadow - 1'b1;
      endcase
      return r;
   endfunction

   // Hold the word until the block takes it, then log what it should answer.
   task automatic issue_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      start    <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (busy);
      predicted = directory_access(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_directory();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size_limit(input logic [SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_shadow = value;
      limit_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word status=%0d way=%0d size=%0d", $realtime,
                     rsp_word.status, rsp_word.way, rsp_word.hit_size);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.status !== want.status || rsp_word.way !== want.way ||
                rsp_word.hit_size !== want.hit_size) begin
               mismatch_count++;
               $display("%0t: expected status=%0d way=%0d size=%0d, %s",
                        $realtime, want.status, want.way, want.hit_size,
                        $sformatf("got status=%0d way=%0d size=%0d",
                                  rsp_word.status, rsp_word.way, rsp_word.hit_size));
            end
         end
      end
   end

   initial begin
      logic [SIZE_W-1:0] phase_limit [PHASES];
      rsp_type           none;
      int                n;
      int                p;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_word  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;

      for (n = 0; n < ENTRIES; n++) begin
         dir_valid[n] = 1'b0;
         dir_key[n]   = '0;
         dir_size[n]  = '0;
         dir_stamp[n] = '0;
      end
      dir_time       = '0;
      limit_shadow   = SIZE_LIMIT_RESET;
      mismatch_count = 0;
      request_count  = 0;
      hit_count      = 0;
      miss_count     = 0;
      insert_count   = 0;
      evict_count    = 0;
      reject_count   = 0;
      limit_count    = 0;
      steady_left    = 0;
      none           = '{STATUS_MISS, '0, '0};
      for (n = 0; n < KEY_POOL; n++)
         key_pool[n] = {$urandom(), $urandom()};

      phase_limit[0] = '0;
      phase_limit[1] = '1;
      phase_limit[2] = SIZE_W'($urandom());
      phase_limit[3] = SIZE_W'(1);
      phase_limit[4] = SIZE_W'($urandom_range(200000, 1000));
      phase_limit[5] = SIZE_LIMIT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows run under the reset size limit.
      for (n = 0; n < N_DIRECTED; n++)
         issue_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].rsp);

      for (p = 0; p < PHASES; p++) begin
         drain_directory();
         write_size_limit(phase_limit[p]);
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            issue_request(random_request(), 1'b0, none);
      end
      drain_directory();

      $display("%0d requests: %0d hits, %0d misses, %0d inserts (%0d evictions), %0d rejects",
               request_count, hit_count, miss_count, insert_count, evict_count, reject_count);
      $display("%0d size limits written; time counter %s", limit_count,
               (dir_time == '1) ? "reached saturation" : "did not saturate");
      if (mismatch_count == 0)
         $display("lru_object_cache_directory: match");
      else
         $display("lru_object_cache_directory: mismatch");
      $finish;
   end

endmodule

// File: lru_object_cache_directory.f
hdl/lcd_pkg.sv
hdl/lcd_store.sv
hdl/lcd_seq.sv
hdl/lru_object_cache_directory.sv
tb/lru_object_cache_directory_tb.sv
